// ===== rtl/core/ctc_pkg.sv =====
package ctc_pkg;

  // Item kind carried by the mode field
  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } mode_e;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } cal_time_t;

  typedef struct packed {
    mode_e     mode;
    cal_time_t load;
  } cal_item_t;

  // Rollover limits; each compare runs one bit wider than its counter
  localparam logic [6:0] SEC_LIMIT   = 7'd60;
  localparam logic [6:0] MIN_LIMIT   = 7'd60;
  localparam logic [5:0] HOUR_LIMIT  = 6'd24;
  localparam logic [4:0] MONTH_LAST  = 5'd12;
  localparam logic [7:0] YEAR_LIMIT  = 8'd99;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [4:0] DAY_FIRST   = 5'd1;
  localparam logic [3:0] MONTH_FIRST = 4'd1;

  // Days per month, indexed by the raw 4-bit month; unused codes give 31
  localparam logic [4:0] DAYS_IN_MONTH [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  localparam cal_time_t TIME_RESET = '{
    second: 6'd0, minute: 6'd0, hour: 5'd0,
    day: 5'd1, month: 4'd1, year: 7'd0
  };

endpackage

// ===== rtl/core/ctc_in_stage.sv =====
module ctc_in_stage
  import ctc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  cal_item_t item_i,
  input  logic      advance_i,
  output logic      stall_o,
  output logic      valid_o,
  output cal_item_t item_o
);

  logic      valid_q, valid_d;
  cal_item_t item_q;

  // Hold while the captured word cannot move on
  assign stall_o = valid_q && !advance_i;
  assign valid_d = stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !stall_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/ctc_next_time.sv =====
module ctc_next_time
  import ctc_pkg::*;
(
  input  cal_time_t cur_i,
  input  cal_item_t item_i,
  output cal_time_t nxt_o
);

  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] day_inc;
  logic [5:0] day_limit;
  logic [4:0] month_inc;
  logic [7:0] year_inc;
  logic       leap_feb;
  logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap, year_wrap;
  cal_time_t  tick;

  always_comb begin
    sec_inc   = {1'b0, cur_i.second} + 7'd1;
    min_inc   = {1'b0, cur_i.minute} + 7'd1;
    hour_inc  = {1'b0, cur_i.hour} + 6'd1;
    day_inc   = {1'b0, cur_i.day} + 6'd1;
    month_inc = {1'b0, cur_i.month} + 5'd1;
    year_inc  = {1'b0, cur_i.year} + 8'd1;

    leap_feb  = (cur_i.month == MONTH_FEB) && (cur_i.year[1:0] == 2'b00);
    day_limit = {1'b0, DAYS_IN_MONTH[cur_i.month]} + {5'd0, leap_feb};

    sec_wrap   = sec_inc >= SEC_LIMIT;
    min_wrap   = sec_wrap && (min_inc >= MIN_LIMIT);
    hour_wrap  = min_wrap && (hour_inc >= HOUR_LIMIT);
    day_wrap   = hour_wrap && (day_inc > day_limit);
    month_wrap = day_wrap && (month_inc > MONTH_LAST);
    year_wrap  = month_wrap && (year_inc > YEAR_LIMIT);

    tick = cur_i;
    tick.second = sec_wrap ? 6'd0 : sec_inc[5:0];
    if (sec_wrap) begin
      tick.minute = min_wrap ? 6'd0 : min_inc[5:0];
    end
    if (min_wrap) begin
      tick.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
    end
    if (hour_wrap) begin
      tick.day = day_wrap ? DAY_FIRST : day_inc[4:0];
    end
    if (day_wrap) begin
      tick.month = month_wrap ? MONTH_FIRST : month_inc[3:0];
    end
    if (month_wrap) begin
      tick.year = year_wrap ? 7'd0 : year_inc[6:0];
    end

    case (item_i.mode)
      MODE_LOAD: nxt_o = item_i.load;
      MODE_TICK: nxt_o = tick;
      default:   nxt_o = tick;
    endcase
  end

endmodule

// ===== rtl/core/calendar_time_counter.sv =====
// Calendar time counter with a two-digit year.
// Input channel (in_valid_i / in_stall_o): a word is taken when valid is
// high and stall is low. mode_i = tick advances the kept time by one second
// with carries through minute, hour, day, month and year; mode_i = load
// replaces all six fields with the load_* values, stored without checks.
// Output channel (out_valid_o / out_stall_i): one word per input word, the
// full time after that word, in input order.
// Path: the input register takes the word; the time register, which doubles
// as the result register, takes the next time once the result slot is free.
// Throughput: one word per clock while out_stall_i is low; the whole carry
// chain is one short block of small increments and compares between those
// two registers.
// Reset: output empty, input stage empty, time set to 00:00:00, day 1,
// month 1, year 0.
// When the receiver stalls, the result holds, one more word waits in the
// input register, and in_stall_o rises only once that register is full.
module calendar_time_counter
  import ctc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [5:0] load_second_i,
  input  logic [5:0] load_minute_i,
  input  logic [4:0] load_hour_i,
  input  logic [4:0] load_day_i,
  input  logic [3:0] load_month_i,
  input  logic [6:0] load_year_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [5:0] second_o,
  output logic [5:0] minute_o,
  output logic [4:0] hour_o,
  output logic [4:0] day_o,
  output logic [3:0] month_o,
  output logic [6:0] year_o
);

  cal_item_t in_item;
  cal_item_t item_q;
  logic      item_valid;
  logic      advance;
  logic      out_valid_q, out_valid_d;
  cal_time_t time_q, time_d;

  // Pack the input word
  always_comb begin
    in_item.mode        = mode_e'(mode_i);
    in_item.load.second = load_second_i;
    in_item.load.minute = load_minute_i;
    in_item.load.hour   = load_hour_i;
    in_item.load.day    = load_day_i;
    in_item.load.month  = load_month_i;
    in_item.load.year   = load_year_i;
  end

  ctc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (in_item),
    .advance_i  (advance),
    .stall_o    (in_stall_o),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  // Move the held word into the time register when the result slot frees up
  assign advance = item_valid && (!out_valid_q || !out_stall_i);

  ctc_next_time u_next_time (
    .cur_i  (time_q),
    .item_i (item_q),
    .nxt_o  (time_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      time_q      <= TIME_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        time_q <= time_d;
      end
    end
  end

  // The time register is the result register
  assign out_valid_o = out_valid_q;
  assign second_o    = time_q.second;
  assign minute_o    = time_q.minute;
  assign hour_o      = time_q.hour;
  assign day_o       = time_q.day;
  assign month_o     = time_q.month;
  assign year_o      = time_q.year;

  // Time only changes when a word moves into the result slot
  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(time_q))
    else $error("time changed without an advancing word");

  // A load lands exactly as given
  a_load_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.mode == MODE_LOAD) |=> (time_q == $past(item_q.load)))
    else $error("loaded time does not match the load word");

  // A tick with no seconds carry bumps the seconds and keeps minute and day
  a_tick_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.mode == MODE_TICK && time_q.second < 6'd59) |=>
    (time_q.second == $past(time_q.second) + 6'd1 &&
     time_q.minute == $past(time_q.minute) && time_q.day == $past(time_q.day)))
    else $error("tick without carry changed more than the seconds");

  // An input stall only ever covers a full input register behind a full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid && out_valid_q && out_stall_i))
    else $error("input stalled with room to move");

endmodule

// ===== test/calendar_time_counter_test.sv =====
`timescale 1ns / 100ps

module calendar_time_counter_test;
  import ctc_pkg::*;

  // Month codes that the day-limit and month-wrap logic cares about
  localparam logic [3:0] FEBRUARY  = 4'd2;
  localparam logic [3:0] APRIL     = 4'd4;
  localparam logic [3:0] JUNE      = 4'd6;
  localparam logic [3:0] SEPTEMBER = 4'd9;
  localparam logic [3:0] NOVEMBER  = 4'd11;
  localparam logic [3:0] DECEMBER  = 4'd12;

  localparam int RANDOM_WORDS = 1200;
  localparam int LONG_HOLD    = 60;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       mode_i;
  logic [5:0] load_second_i;
  logic [5:0] load_minute_i;
  logic [4:0] load_hour_i;
  logic [4:0] load_day_i;
  logic [3:0] load_month_i;
  logic [6:0] load_year_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [5:0] second_o;
  logic [5:0] minute_o;
  logic [4:0] hour_o;
  logic [4:0] day_o;
  logic [3:0] month_o;
  logic [6:0] year_o;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    mode_e     mode;
    cal_time_t load;
    bit        typed;
    cal_time_t want;
  } stim_row_t;

  stim_row_t directed_rows[$];
  cal_time_t calendar_now;          // predicted time after the last accepted word
  cal_time_t expected_times[$];     // predicted results still in flight
  int        words_sent;
  int        loads_sent;
  int        results_seen;
  int        mismatches;
  int        burst_left;

  calendar_time_counter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .load_second_i (load_second_i),
    .load_minute_i (load_minute_i),
    .load_hour_i   (load_hour_i),
    .load_day_i    (load_day_i),
    .load_month_i  (load_month_i),
    .load_year_i   (load_year_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .second_o      (second_o),
    .minute_o      (minute_o),
    .hour_o        (hour_o),
    .day_o         (day_o),
    .month_o       (month_o),
    .year_o        (year_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Build a time from plain numbers; values beyond a field's range keep their low bits
  function automatic cal_time_t hms_date(int s, int mi, int h, int d, int mo, int y);
    cal_time_t t;
    t.second = 6'(s);
    t.minute = 6'(mi);
    t.hour   = 5'(h);
    t.day    = 5'(d);
    t.month  = 4'(mo);
    t.year   = 7'(y);
    return t;
  endfunction

  // Length of a month; codes outside 1..12 fall back to 31
  function automatic logic [5:0] days_in(logic [3:0] month, logic [6:0] year);
    case (month)
      APRIL, JUNE, SEPTEMBER, NOVEMBER: days_in = 6'd30;
      FEBRUARY: days_in = (year[1:0] == 2'd0) ? 6'd29 : 6'd28;
      default: days_in = 6'd31;
    endcase
  endfunction

  // Advance the calendar by one second. Each increment is one bit wider than
  // its field, so out-of-range loaded values wrap on the wide compare.
  function automatic cal_time_t advance_second(cal_time_t t);
    cal_time_t  n;
    logic [6:0] sec_next;
    logic [6:0] min_next;
    logic [5:0] hour_next;
    logic [5:0] day_next;
    logic [4:0] month_next;
    logic [7:0] year_next;
    n = t;
    sec_next = {1'b0, t.second} + 7'd1;
    if (sec_next < 7'd60) begin
      n.second = sec_next[5:0];
      return n;
    end
    n.second = '0;
    min_next = {1'b0, t.minute} + 7'd1;
    if (min_next < 7'd60) begin
      n.minute = min_next[5:0];
      return n;
    end
    n.minute = '0;
    hour_next = {1'b0, t.hour} + 6'd1;
    if (hour_next < 6'd24) begin
      n.hour = hour_next[4:0];
      return n;
    end
    n.hour = '0;
    day_next = {1'b0, t.day} + 6'd1;
    if (day_next <= days_in(t.month, t.year)) begin
      n.day = day_next[4:0];
      return n;
    end
    n.day = 5'd1;
    month_next = {1'b0, t.month} + 5'd1;
    if (month_next <= {1'b0, DECEMBER}) begin
      n.month = month_next[3:0];
      return n;
    end
    n.month = 4'd1;
    year_next = {1'b0, t.year} + 8'd1;
    n.year = (year_next > 8'd99) ? 7'd0 : year_next[6:0];
    return n;
  endfunction

  // Every bit pattern a field can carry; used for noise loads and for the
  // ignored load fields of a tick
  function automatic cal_time_t raw_fields();
    cal_time_t t;
    t.second = 6'($urandom_range(0, 63));
    t.minute = 6'($urandom_range(0, 63));
    t.hour   = 5'($urandom_range(0, 31));
    t.day    = 5'($urandom_range(0, 31));
    t.month  = 4'($urandom_range(0, 15));
    t.year   = 7'($urandom_range(0, 127));
    return t;
  endfunction

  // A legal time a few seconds short of a minute, hour, day, month or year edge
  function automatic cal_time_t near_rollover();
    cal_time_t t;
    t.year   = ($urandom_range(0, 3) == 0) ? 7'd99 : 7'($urandom_range(0, 99));
    t.month  = ($urandom_range(0, 3) == 0) ? DECEMBER : 4'($urandom_range(1, 12));
    t.hour   = ($urandom_range(0, 3) != 0) ? 5'd23 : 5'($urandom_range(0, 23));
    t.minute = ($urandom_range(0, 3) != 0) ? 6'd59 : 6'($urandom_range(0, 59));
    t.second = 6'($urandom_range(50, 59));
    case ($urandom_range(0, 3))
      0: t.day = 5'($urandom_range(1, days_in(t.month, t.year)));
      1: t.day = 5'(days_in(t.month, t.year) - 6'd1);
      default: t.day = 5'(days_in(t.month, t.year));
    endcase
    return t;
  endfunction

  task automatic add_row(mode_e m, cal_time_t ld, bit typed, cal_time_t want);
    stim_row_t row;
    row.mode  = m;
    row.load  = ld;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Offer one word from the falling edge and hold it until the block takes it;
  // valid stays high on return so back-to-back words need no gap
  task automatic send_word(mode_e m, cal_time_t ld, bit typed, cal_time_t want);
    @(negedge clk_i);
    in_valid_i    = 1'b1;
    mode_i        = m;
    load_second_i = ld.second;
    load_minute_i = ld.minute;
    load_hour_i   = ld.hour;
    load_day_i    = ld.day;
    load_month_i  = ld.month;
    load_year_i   = ld.year;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (m == MODE_LOAD) begin
      calendar_now = ld;
      loads_sent++;
    end else begin
      calendar_now = advance_second(calendar_now);
    end
    expected_times.push_back(typed ? want : calendar_now);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(MODE_TICK, raw_fields(), 1'b0, '0);
  endtask

  // Drop valid for a random stretch: mostly none or short, now and then long,
  // with bursts of back-to-back words in between
  task automatic sender_gap();
    int n;
    if (burst_left > 0) begin
      burst_left--;
      n = 0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:54]:  n = 0;
        [55:84]: n = $urandom_range(1, 3);
        [85:94]: n = $urandom_range(4, 10);
        [95:96]: n = $urandom_range(20, 40);
        default: begin
          burst_left = $urandom_range(20, 80);
          n = 0;
        end
      endcase
    end
    if (n > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Hold the input until every predicted result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_times.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, calm stretches, and one forced long hold once a
  // few dozen results are in, so the input register fills and stall rises
  initial begin : receiver
    int  hold_left;
    int  calm_left;
    bit  long_done;
    hold_left = 0;
    calm_left = 0;
    long_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (!long_done && results_seen >= 30) begin
        long_done   = 1'b1;
        hold_left   = LONG_HOLD - 1;
        out_stall_i = 1'b1;
      end else if (calm_left > 0) begin
        out_stall_i = 1'b0;
        calm_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:49]: out_stall_i = 1'b0;
          [50:84]: begin
            out_stall_i = 1'b1;
            hold_left   = $urandom_range(0, 2);
          end
          [85:94]: begin
            out_stall_i = 1'b0;
            calm_left   = $urandom_range(20, 60);
          end
          default: begin
            out_stall_i = 1'b1;
            hold_left   = $urandom_range(10, 40);
          end
        endcase
      end
    end
  end

  // Check every word the receiver takes against the oldest prediction
  always @(posedge clk_i) begin : result_check
    cal_time_t got;
    cal_time_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = hms_date(second_o, minute_o, hour_o, day_o, month_o, year_o);
      results_seen++;
      if (expected_times.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected word %0d:%0d:%0d day %0d month %0d year %0d",
                   $realtime, got.second, got.minute, got.hour, got.day,
                   got.month, got.year);
      end else begin
        want = expected_times.pop_front();
        if (got.second !== want.second || got.minute !== want.minute ||
            got.hour !== want.hour || got.day !== want.day ||
            got.month !== want.month || got.year !== want.year) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("[%0t] word %0d: expected %0d:%0d:%0d d%0d m%0d y%0d,",
                   $realtime, results_seen, want.second, want.minute, want.hour,
                   want.day, want.month, want.year);
            $display(" got %0d:%0d:%0d d%0d m%0d y%0d",
                     got.second, got.minute, got.hour, got.day, got.month,
                     got.year);
          end
        end
      end
    end
  end

  initial begin : stimulus
    bit paused;
    int run;
    paused        = 1'b0;
    words_sent    = 0;
    loads_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_TICK;
    load_second_i = '0;
    load_minute_i = '0;
    load_hour_i   = '0;
    load_day_i    = '0;
    load_month_i  = '0;
    load_year_i   = '0;
    calendar_now  = hms_date(0, 0, 0, 1, 1, 0);

    // Directed table. Expected times are spelled out only for the first tick, the
    // full rollover, reset reload and all-ones load; the rest use the predictor.
    add_row(MODE_TICK, raw_fields(), 1'b1, hms_date(1, 0, 0, 1, 1, 0));
    add_row(MODE_LOAD, hms_date(59, 59, 23, 31, 12, 99), 1'b1,
            hms_date(59, 59, 23, 31, 12, 99));
    add_row(MODE_TICK, raw_fields(), 1'b1, hms_date(0, 0, 0, 1, 1, 0));
    add_row(MODE_LOAD, hms_date(0, 0, 0, 1, 1, 0), 1'b1, hms_date(0, 0, 0, 1, 1, 0));
    // leap February, into the 29th and out of it
    add_row(MODE_LOAD, hms_date(59, 59, 23, 28, 2, 4), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    add_row(MODE_LOAD, hms_date(59, 59, 23, 29, 2, 4), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    // common February and year zero as a leap year
    add_row(MODE_LOAD, hms_date(59, 59, 23, 28, 2, 3), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    add_row(MODE_LOAD, hms_date(59, 59, 23, 28, 2, 0), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    // thirty-day month
    add_row(MODE_LOAD, hms_date(59, 59, 23, 30, 4, 50), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    // every field at its all-ones pattern, stored raw, then wrapped on a tick
    add_row(MODE_LOAD, hms_date(63, 63, 31, 31, 15, 127), 1'b1,
            hms_date(63, 63, 31, 31, 15, 127));
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    // day zero with month zero
    add_row(MODE_LOAD, hms_date(59, 59, 23, 0, 0, 7), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    // day past the end of its month
    add_row(MODE_LOAD, hms_date(59, 59, 23, 31, 4, 20), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    // month beyond December
    add_row(MODE_LOAD, hms_date(59, 59, 23, 31, 13, 20), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);
    // year above the two-digit limit
    add_row(MODE_LOAD, hms_date(59, 59, 23, 31, 12, 100), 1'b0, '0);
    add_row(MODE_TICK, raw_fields(), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].mode, directed_rows[i].load, directed_rows[i].typed,
                directed_rows[i].want);
      sender_gap();
    end
    drain();

    // Mostly legal times just short of an edge followed by a run of ticks;
    // the rest raw loads and stray ticks
    while (words_sent < directed_rows.size() + RANDOM_WORDS) begin
      if (!paused && words_sent >= directed_rows.size() + RANDOM_WORDS / 2) begin
        paused = 1'b1;
        drain();
      end
      case ($urandom_range(0, 99)) inside
        [0:69]: begin
          send_word(MODE_LOAD, near_rollover(), 1'b0, '0);
          sender_gap();
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 12);
        end
        [70:84]: begin
          send_word(MODE_LOAD, raw_fields(), 1'b0, '0);
          sender_gap();
          run = $urandom_range(1, 8);
        end
        default: run = $urandom_range(1, 5);
      endcase
      repeat (run) begin
        send_tick();
        sender_gap();
      end
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words (%0d loads, %0d ticks), checked %0d results, %0d mismatches.",
             words_sent, loads_sent, words_sent - loads_sent, results_seen, mismatches);
    $display("Covered leap and common February, month, year and out-of-range rollovers.");
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ctc_pkg.sv
rtl/core/ctc_in_stage.sv
rtl/core/ctc_next_time.sv
rtl/core/calendar_time_counter.sv
test/calendar_time_counter_test.sv
